// File: hw/rtl/lzc_pkg.sv
// shared types, constants and saturating arithmetic for the lorenz/chua derivative core
package lzc_pkg;

    // fixed word layout of every payload field and coefficient
    localparam int WORD_BITS         = 40;
    localparam int FRAC_BITS_DEFAULT = 24;
    localparam int CFG_INDEX_BITS    = 3;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_SELECT      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIGMA       = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_RHO         = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BETA        = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOPE_INNER = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOPE_OUTER = 3'd6;

    typedef logic signed [WORD_BITS-1:0] word_t;

    localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // value plus clip indication
    typedef struct packed {
        logic  clip;
        word_t v;
    } sat_t;

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        word_t tangent_x;
        word_t tangent_y;
        word_t tangent_z;
    } in_t;

    typedef struct packed {
        word_t rate_x;
        word_t rate_y;
        word_t rate_z;
        word_t tangent_rate_x;
        word_t tangent_rate_y;
        word_t tangent_rate_z;
        logic  saturated;
    } out_t;

    // saturating add
    function automatic sat_t sat_add(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        sat_t r;
        s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
        begin
            r.clip = 1'b1;
            r.v    = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            r.clip = 1'b0;
            r.v    = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

    // saturating subtract
    function automatic sat_t sat_sub(word_t a, word_t b);
        logic [WORD_BITS:0] s;
        sat_t r;
        s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
        if (s[WORD_BITS] != s[WORD_BITS-1])
        begin
            r.clip = 1'b1;
            r.v    = s[WORD_BITS] ? WORD_MIN : WORD_MAX;
        end
        else
        begin
            r.clip = 1'b0;
            r.v    = s[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/lzc_mul.sv
// four-stage fixed-point multiplier with rounding and saturation
module lzc_mul
    import lzc_pkg::*;
#(
    parameter int AW        = WORD_BITS,
    parameter int BW        = WORD_BITS,
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [AW-1:0] a,
    input  logic signed [BW-1:0] b,
    output word_t                q,
    output logic                 clip
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;
    localparam int SW = PW + 1 - FRAC_BITS;
    localparam logic [PW:0]   HALF    = (PW+1)'(1) << (FRAC_BITS - 1);
    localparam logic [SW-1:0] LIM_POS = SW'((64'd1 << (WORD_BITS - 1)) - 64'd1);
    localparam logic [SW-1:0] LIM_NEG = SW'(64'd1 << (WORD_BITS - 1));

    logic [AW-1:0]      ma_reg, ma_next;
    logic [BW-1:0]      mb_reg, mb_next;
    logic               neg1_reg, neg2_reg, neg3_reg;
    logic [AL+BL-1:0]   p00_reg, p00_next;
    logic [AL+BH-1:0]   p01_reg, p01_next;
    logic [AH+BL-1:0]   p10_reg, p10_next;
    logic [AH+BH-1:0]   p11_reg, p11_next;
    logic [PW-1:0]      prod_reg, prod_next;
    logic [PW:0]        rnd;
    logic [SW-1:0]      shifted, lim, mag;
    logic [WORD_BITS-1:0] mag_w;
    word_t              q_reg, q_next;
    logic               clip_reg, clip_next;

    // operand magnitudes
    always_comb
    begin
        ma_next = a[AW-1] ? AW'(~a + 1'b1) : AW'(a);
        mb_next = b[BW-1] ? BW'(~b + 1'b1) : BW'(b);
    end

    // partial products
    always_comb
    begin
        p00_next = (AL+BL)'(ma_reg[AL-1:0]) * (AL+BL)'(mb_reg[BL-1:0]);
        p01_next = (AL+BH)'(ma_reg[AL-1:0]) * (AL+BH)'(mb_reg[BW-1:BL]);
        p10_next = (AH+BL)'(ma_reg[AW-1:AL]) * (AH+BL)'(mb_reg[BL-1:0]);
        p11_next = (AH+BH)'(ma_reg[AW-1:AL]) * (AH+BH)'(mb_reg[BW-1:BL]);
    end

    // partial product sum
    always_comb
    begin
        prod_next = (PW'(p11_reg) << (AL + BL)) + (PW'(p10_reg) << AL)
                  + (PW'(p01_reg) << BL) + PW'(p00_reg);
    end

    // round half away from zero, clip, restore sign
    always_comb
    begin
        rnd       = {1'b0, prod_reg} + HALF;
        shifted   = rnd[PW:FRAC_BITS];
        lim       = neg3_reg ? LIM_NEG : LIM_POS;
        clip_next = shifted > lim;
        mag       = clip_next ? lim : shifted;
        mag_w     = mag[WORD_BITS-1:0];
        q_next    = neg3_reg ? (~mag_w + 1'b1) : mag_w;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            neg1_reg <= a[AW-1] ^ b[BW-1];
            p00_reg  <= p00_next;
            p01_reg  <= p01_next;
            p10_reg  <= p10_next;
            p11_reg  <= p11_next;
            neg2_reg <= neg1_reg;
            prod_reg <= prod_next;
            neg3_reg <= neg2_reg;
            q_reg    <= q_next;
            clip_reg <= clip_next;
        end
    end

    assign q    = q_reg;
    assign clip = clip_reg;

endmodule

// File: hw/rtl/chaotic_ode_rhs_lorenz_chua_core.sv
// top level of the lorenz/chua derivative and tangent derivative core
// usage:
// - in_valid/in_stall/in_data carry one point and one tangent vector per transfer;
//   a transfer happens on a rising edge with in_valid high and in_stall low
// - out_valid/out_stall/out_data return the field derivative, the jacobian times
//   tangent product and a saturation flag, one result per input transfer, in order
// - cfg_write/cfg_index/cfg_data write the mode and coefficients; write only while
//   the core holds no work
// - throughput is one transfer per cycle when nothing stalls
// - the longest path is the chua diode slope path: five dependent products,
//   each through a four-stage multiplier, plus the saturating add stages between
// - when out_stall holds a valid result, the whole pipeline freezes and in_stall
//   rises in the same cycle; nothing is dropped or repeated
// - reset empties the pipeline and loads the default coefficients (lorenz mode,
//   sigma 10, rho 28, beta 8/3, alpha 9, m0 -1.143, m1 -0.714)
module chaotic_ode_rhs_lorenz_chua_core
    import lzc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  in_t                       in_data,
    output logic                      out_valid,
    input  logic                      out_stall,
    output out_t                      out_data,
    input  logic                      cfg_write,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]      cfg_data
);

    localparam int    W      = WORD_BITS;
    localparam int    DEPTH  = 24;
    localparam longint ONE_Q = 64'sd1 << FRAC_BITS;
    localparam longint EPS_Q = (ONE_Q + 25) / 50;

    localparam word_t SIGMA_RST = W'(10 * ONE_Q);
    localparam word_t RHO_RST   = W'(28 * ONE_Q);
    localparam word_t BETA_RST  = W'((8 * ONE_Q + 1) / 3);
    localparam word_t ALPHA_RST = W'(9 * ONE_Q);
    localparam word_t M0_RST    = W'(-((1143 * ONE_Q + 500) / 1000));
    localparam word_t M1_RST    = W'(-((714 * ONE_Q + 500) / 1000));

    localparam word_t                 ONE_W = W'(ONE_Q);
    localparam logic signed [W+1:0]   HI_C  = (W+2)'(ONE_Q + EPS_Q);
    localparam logic signed [W+1:0]   LO_C  = (W+2)'(-(ONE_Q + EPS_Q));
    localparam logic signed [W+1:0]   IN_C  = (W+2)'(ONE_Q - EPS_Q);
    localparam logic signed [W+6:0]   ONE_A = (W+7)'(ONE_Q);

    typedef struct packed {
        logic outer;
        logic inner;
        logic blend;
    } zone_t;

    // configuration registers
    logic  sel_reg;
    word_t sigma_reg, rho_reg, beta_reg, alpha_reg, m0_reg, m1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            sigma_reg <= SIGMA_RST;
            rho_reg   <= RHO_RST;
            beta_reg  <= BETA_RST;
            alpha_reg <= ALPHA_RST;
            m0_reg    <= M0_RST;
            m1_reg    <= M1_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SELECT:      sel_reg   <= cfg_data[0];
                REG_SIGMA:       sigma_reg <= cfg_data;
                REG_RHO:         rho_reg   <= cfg_data;
                REG_BETA:        beta_reg  <= cfg_data;
                REG_ALPHA:       alpha_reg <= cfg_data;
                REG_SLOPE_INNER: m0_reg    <= cfg_data;
                REG_SLOPE_OUTER: m1_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // coefficient differences of the diode
    sat_t off, dm;
    always_comb
    begin
        off = sat_sub(m0_reg, m1_reg);
        dm  = sat_sub(m1_reg, m0_reg);
    end

    // pipeline advance: freeze only while a held result is refused
    logic          en;
    logic          out_valid_reg;
    out_t          out_data_reg;
    logic [0:DEPTH] v_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {in_valid, v_reg[0:DEPTH-1]};
            out_valid_reg <= v_reg[DEPTH];
        end
    end

    // stage registers and delay lines
    in_t   in_reg;
    logic  mode0_reg;
    logic  mode_reg  [1:DEPTH];
    logic  clip_reg  [1:DEPTH];
    zone_t zone_reg  [1:14];
    logic  xneg_reg  [1:9];
    word_t a_reg     [1:9];
    word_t a2_reg    [6:9];
    word_t y_reg     [1:4];
    word_t dx_reg    [1:15];
    word_t dy_reg    [1:19];
    word_t ymx_reg   [1:15];
    word_t c1_reg    [1:4];
    word_t c4_reg    [1:4];
    word_t gi_reg    [5:14];
    word_t go_reg    [5:14];
    word_t diff_reg  [5:10];
    word_t res1_reg  [5:DEPTH];
    word_t res2_reg  [5:DEPTH];
    word_t res4_reg  [5:DEPTH];
    word_t res5_reg  [5:DEPTH];
    word_t lr0_reg   [5:19];
    word_t lr3_reg   [5:DEPTH];
    word_t res0_reg  [20:DEPTH];
    logic signed [W+1:0] s_reg;
    logic signed [W+7:0] dads_reg;
    word_t g_reg, dg_reg, q_reg;

    logic [0:DEPTH] flag_add;

    // multiplier results
    word_t p_sy, p_sdy, p_xrz, p_dxrz, p_xy, p_bz, p_xdz, p_dxy, p_xdy, p_bdz;
    word_t p_by, p_bdy, p_gi, p_m1x, p_aa, p_a3, p_dfs, p_dms, p_dfd, p_au, p_dxt, p_aq;
    logic  c_sy, c_sdy, c_xrz, c_dxrz, c_xy, c_bz, c_xdz, c_dxy, c_xdy, c_bdz;
    logic  c_by, c_bdy, c_gi, c_m1x, c_aa, c_a3, c_dfs, c_dms, c_dfd, c_au, c_dxt, c_aq;

    // stage 0: first differences, chua linear rows, diode zone and blend fraction
    sat_t ymx, rz, dymdx, c1a, c1, c4a, c4;
    logic signed [W+1:0] xe, ax, t0;
    logic signed [W+6:0] te, at;
    zone_t zn0;
    word_t a0;
    always_comb
    begin
        ymx   = sat_sub(in_reg.pos_y, in_reg.pos_x);
        rz    = sat_sub(rho_reg, in_reg.pos_z);
        dymdx = sat_sub(in_reg.tangent_y, in_reg.tangent_x);
        c1a   = sat_sub(in_reg.pos_x, in_reg.pos_y);
        c1    = sat_add(c1a.v, in_reg.pos_z);
        c4a   = sat_sub(in_reg.tangent_x, in_reg.tangent_y);
        c4    = sat_add(c4a.v, in_reg.tangent_z);
        xe    = {{2{in_reg.pos_x[W-1]}}, in_reg.pos_x};
        ax    = xe[W+1] ? -xe : xe;
        zn0.outer = (xe > HI_C) || (xe < LO_C);
        zn0.inner = !zn0.outer && (ax < IN_C);
        zn0.blend = !zn0.outer && !zn0.inner;
        t0    = ax - IN_C;
        te    = {{5{t0[W+1]}}, t0};
        at    = (te <<< 4) + (te <<< 3) + te;
        if (!zn0.blend)
            a0 = '0;
        else if (at > ONE_A)
            a0 = ONE_W;
        else
            a0 = at[W-1:0];
    end

    // stage 4: lorenz sums, chua outputs of beta, outer diode form and difference
    sat_t lr1, lr2, lr4a, lr4, lr5a, lr5, cr2, cr5, go4, diff4;
    always_comb
    begin
        lr1   = sat_sub(p_xrz, y_reg[4]);
        lr2   = sat_sub(p_xy, p_bz);
        lr4a  = sat_sub(p_dxrz, dy_reg[4]);
        lr4   = sat_sub(lr4a.v, p_xdz);
        lr5a  = sat_add(p_dxy, p_xdy);
        lr5   = sat_sub(lr5a.v, p_bdz);
        cr2   = sat_sub('0, p_by);
        cr5   = sat_sub('0, p_bdy);
        go4   = xneg_reg[4] ? sat_sub(p_m1x, off.v) : sat_add(p_m1x, off.v);
        diff4 = sat_sub(go4.v, p_gi);
    end

    // stage 9: smoothstep and its derivative
    logic signed [W+1:0] a2e, a3e, s9;
    logic signed [W+7:0] a8, a28, d8, d150, dads9;
    always_comb
    begin
        a2e   = {{2{a2_reg[9][W-1]}}, a2_reg[9]};
        a3e   = {{2{p_a3[W-1]}}, p_a3};
        s9    = a2e + (a2e <<< 1) - (a3e <<< 1);
        a8    = {{8{a_reg[9][W-1]}}, a_reg[9]};
        a28   = {{8{a2_reg[9][W-1]}}, a2_reg[9]};
        d8    = a8 - a28;
        d150  = (d8 <<< 7) + (d8 <<< 4) + (d8 <<< 2) + (d8 <<< 1);
        dads9 = xneg_reg[9] ? -d150 : d150;
    end

    // stage 14: blended diode value and slope
    sat_t gb, t1, db;
    word_t g14, dg14;
    always_comb
    begin
        gb = sat_add(gi_reg[14], p_dfs);
        t1 = sat_add(m0_reg, p_dms);
        db = sat_add(t1.v, p_dfd);
        if (zone_reg[14].outer)
        begin
            g14  = go_reg[14];
            dg14 = m1_reg;
        end
        else if (zone_reg[14].inner)
        begin
            g14  = gi_reg[14];
            dg14 = m0_reg;
        end
        else
        begin
            g14  = gb.v;
            dg14 = db.v;
        end
    end

    // stage 15 and 19: chua first row operands
    sat_t u15, tmp15, q19;
    always_comb
    begin
        u15   = sat_sub(ymx_reg[15], g_reg);
        tmp15 = sat_add(ONE_W, dg_reg);
        q19   = sat_sub(dy_reg[19], p_dxt);
    end

    // clip flags, each gated by the mode and diode zone that use the step
    always_comb
    begin
        flag_add = '0;
        flag_add[0] = ymx.clip | (mode0_reg
                    ? (off.clip | c1a.clip | c1.clip | c4a.clip | c4.clip)
                    : (rz.clip | dymdx.clip));
        flag_add[4] = mode_reg[4]
                    ? (c_by | c_bdy | cr2.clip | cr5.clip
                       | ((zone_reg[4].inner | zone_reg[4].blend) & c_gi)
                       | ((zone_reg[4].outer | zone_reg[4].blend) & (c_m1x | go4.clip))
                       | (zone_reg[4].blend & diff4.clip))
                    : (c_sy | c_sdy | c_xrz | c_dxrz | c_xy | c_bz | c_xdz | c_dxy
                       | c_xdy | c_bdz | lr1.clip | lr2.clip | lr4a.clip | lr4.clip
                       | lr5a.clip | lr5.clip);
        flag_add[5]  = mode_reg[5] & zone_reg[5].blend & c_aa;
        flag_add[9]  = mode_reg[9] & zone_reg[9].blend & c_a3;
        flag_add[14] = mode_reg[14] & zone_reg[14].blend
                     & (c_dfs | c_dms | c_dfd | gb.clip | t1.clip | db.clip | dm.clip);
        flag_add[15] = mode_reg[15] & (u15.clip | tmp15.clip);
        flag_add[19] = mode_reg[19] & (c_au | c_dxt | q19.clip);
        flag_add[24] = mode_reg[24] & c_aq;
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_reg    <= in_data;
            mode0_reg <= sel_reg;

            mode_reg[1] <= mode0_reg;
            clip_reg[1] <= flag_add[0];
            for (int k = 2; k <= DEPTH; k++)
            begin
                mode_reg[k] <= mode_reg[k-1];
                clip_reg[k] <= clip_reg[k-1] | flag_add[k-1];
            end

            zone_reg[1] <= zn0;
            for (int k = 2; k <= 14; k++)
                zone_reg[k] <= zone_reg[k-1];

            xneg_reg[1] <= in_reg.pos_x[W-1];
            a_reg[1]    <= a0;
            for (int k = 2; k <= 9; k++)
            begin
                xneg_reg[k] <= xneg_reg[k-1];
                a_reg[k]    <= a_reg[k-1];
            end

            a2_reg[6] <= p_aa;
            for (int k = 7; k <= 9; k++)
                a2_reg[k] <= a2_reg[k-1];

            y_reg[1]  <= in_reg.pos_y;
            c1_reg[1] <= c1.v;
            c4_reg[1] <= c4.v;
            for (int k = 2; k <= 4; k++)
            begin
                y_reg[k]  <= y_reg[k-1];
                c1_reg[k] <= c1_reg[k-1];
                c4_reg[k] <= c4_reg[k-1];
            end

            dx_reg[1]  <= in_reg.tangent_x;
            ymx_reg[1] <= ymx.v;
            for (int k = 2; k <= 15; k++)
            begin
                dx_reg[k]  <= dx_reg[k-1];
                ymx_reg[k] <= ymx_reg[k-1];
            end

            dy_reg[1] <= in_reg.tangent_y;
            for (int k = 2; k <= 19; k++)
                dy_reg[k] <= dy_reg[k-1];

            // stage 4 results
            gi_reg[5]   <= p_gi;
            go_reg[5]   <= go4.v;
            diff_reg[5] <= diff4.v;
            for (int k = 6; k <= 14; k++)
            begin
                gi_reg[k] <= gi_reg[k-1];
                go_reg[k] <= go_reg[k-1];
            end
            for (int k = 6; k <= 10; k++)
                diff_reg[k] <= diff_reg[k-1];

            res1_reg[5] <= mode_reg[4] ? c1_reg[4] : lr1.v;
            res2_reg[5] <= mode_reg[4] ? cr2.v : lr2.v;
            res4_reg[5] <= mode_reg[4] ? c4_reg[4] : lr4.v;
            res5_reg[5] <= mode_reg[4] ? cr5.v : lr5.v;
            lr0_reg[5]  <= p_sy;
            lr3_reg[5]  <= p_sdy;
            for (int k = 6; k <= DEPTH; k++)
            begin
                res1_reg[k] <= res1_reg[k-1];
                res2_reg[k] <= res2_reg[k-1];
                res4_reg[k] <= res4_reg[k-1];
                res5_reg[k] <= res5_reg[k-1];
                lr3_reg[k]  <= lr3_reg[k-1];
            end
            for (int k = 6; k <= 19; k++)
                lr0_reg[k] <= lr0_reg[k-1];

            s_reg    <= s9;
            dads_reg <= dads9;
            g_reg    <= g14;
            dg_reg   <= dg14;
            q_reg    <= q19.v;

            res0_reg[20] <= mode_reg[19] ? p_au : lr0_reg[19];
            for (int k = 21; k <= DEPTH; k++)
                res0_reg[k] <= res0_reg[k-1];

            // output register
            out_data_reg.rate_x         <= res0_reg[DEPTH];
            out_data_reg.rate_y         <= res1_reg[DEPTH];
            out_data_reg.rate_z         <= res2_reg[DEPTH];
            out_data_reg.tangent_rate_x <= mode_reg[DEPTH] ? p_aq : lr3_reg[DEPTH];
            out_data_reg.tangent_rate_y <= res4_reg[DEPTH];
            out_data_reg.tangent_rate_z <= res5_reg[DEPTH];
            out_data_reg.saturated      <= clip_reg[DEPTH] | flag_add[DEPTH];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // lorenz products, launched at stage 0
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_sy
    (.clk(clk), .en(en), .a(sigma_reg), .b(ymx.v), .q(p_sy), .clip(c_sy));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_sdy
    (.clk(clk), .en(en), .a(sigma_reg), .b(dymdx.v), .q(p_sdy), .clip(c_sdy));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_xrz
    (.clk(clk), .en(en), .a(in_reg.pos_x), .b(rz.v), .q(p_xrz), .clip(c_xrz));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_dxrz
    (.clk(clk), .en(en), .a(in_reg.tangent_x), .b(rz.v), .q(p_dxrz), .clip(c_dxrz));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_xy
    (.clk(clk), .en(en), .a(in_reg.pos_x), .b(in_reg.pos_y), .q(p_xy), .clip(c_xy));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_bz
    (.clk(clk), .en(en), .a(beta_reg), .b(in_reg.pos_z), .q(p_bz), .clip(c_bz));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_xdz
    (.clk(clk), .en(en), .a(in_reg.pos_x), .b(in_reg.tangent_z), .q(p_xdz), .clip(c_xdz));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_dxy
    (.clk(clk), .en(en), .a(in_reg.tangent_x), .b(in_reg.pos_y), .q(p_dxy), .clip(c_dxy));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_xdy
    (.clk(clk), .en(en), .a(in_reg.pos_x), .b(in_reg.tangent_y), .q(p_xdy), .clip(c_xdy));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_bdz
    (.clk(clk), .en(en), .a(beta_reg), .b(in_reg.tangent_z), .q(p_bdz), .clip(c_bdz));

    // chua products, launched at stage 0
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_by
    (.clk(clk), .en(en), .a(beta_reg), .b(in_reg.pos_y), .q(p_by), .clip(c_by));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_bdy
    (.clk(clk), .en(en), .a(beta_reg), .b(in_reg.tangent_y), .q(p_bdy), .clip(c_bdy));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_gi
    (.clk(clk), .en(en), .a(m0_reg), .b(in_reg.pos_x), .q(p_gi), .clip(c_gi));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_m1x
    (.clk(clk), .en(en), .a(m1_reg), .b(in_reg.pos_x), .q(p_m1x), .clip(c_m1x));

    // blend fraction powers, launched at stages 1 and 5
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_aa
    (.clk(clk), .en(en), .a(a_reg[1]), .b(a_reg[1]), .q(p_aa), .clip(c_aa));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_a3
    (.clk(clk), .en(en), .a(p_aa), .b(a_reg[5]), .q(p_a3), .clip(c_a3));

    // blend terms, launched at stage 10
    lzc_mul #(.AW(W), .BW(W+2), .FRAC_BITS(FRAC_BITS)) u_mul_dfs
    (.clk(clk), .en(en), .a(diff_reg[10]), .b(s_reg), .q(p_dfs), .clip(c_dfs));
    lzc_mul #(.AW(W), .BW(W+2), .FRAC_BITS(FRAC_BITS)) u_mul_dms
    (.clk(clk), .en(en), .a(dm.v), .b(s_reg), .q(p_dms), .clip(c_dms));
    lzc_mul #(.AW(W), .BW(W+8), .FRAC_BITS(FRAC_BITS)) u_mul_dfd
    (.clk(clk), .en(en), .a(diff_reg[10]), .b(dads_reg), .q(p_dfd), .clip(c_dfd));

    // chua first rows, launched at stages 15 and 20
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_au
    (.clk(clk), .en(en), .a(alpha_reg), .b(u15.v), .q(p_au), .clip(c_au));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_dxt
    (.clk(clk), .en(en), .a(dx_reg[15]), .b(tmp15.v), .q(p_dxt), .clip(c_dxt));
    lzc_mul #(.AW(W), .BW(W), .FRAC_BITS(FRAC_BITS)) u_mul_aq
    (.clk(clk), .en(en), .a(alpha_reg), .b(q_reg), .q(p_aq), .clip(c_aq));

    // checks
    a_last_stage_lands: assert property (@(posedge clk) disable iff (!rst_n)
        en && v_reg[DEPTH] |=> out_valid)
        else $error("finished item did not reach the output register");

    a_zone_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] |-> $onehot({zone_reg[1].outer, zone_reg[1].inner, zone_reg[1].blend}))
        else $error("diode zone decode not one-hot");

    a_blend_range: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[1] |-> !a_reg[1][W-1] && (a_reg[1] <= ONE_W))
        else $error("blend fraction outside zero to one");

endmodule

// File: test/testbench.sv
// self-checking testbench for the lorenz/chua derivative core
`timescale 1ns / 1ps

module testbench;
    import lzc_pkg::*;

    localparam longint ONE_Q   = 64'sd1 <<< 24;
    localparam longint EPS_Q   = (ONE_Q + 25) / 50;
    localparam longint WMAX_Q  = (64'sd1 <<< (WORD_BITS - 1)) - 1;
    localparam longint WMIN_Q  = -WMAX_Q - 1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NONE = 3'd7;
    localparam int     LATENCY = 25;

    typedef struct {
        bit   chua;
        in_t  d;
        bit   typed;
        out_t want;
    } row_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    in_t                       in_data;
    logic                      out_valid;
    logic                      out_stall;
    out_t                      out_data;
    logic                      cfg_write;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [WORD_BITS-1:0]      cfg_data;

    // mirror of the coefficient registers
    bit     mode_chua;
    longint sigma_q, rho_q, beta_q, alpha_q, m0_q, m1_q;
    bit     clip_seen;

    out_t   expected_rates[$];
    int     mismatches;
    bit     gaps_on;
    int     hold_request;
    row_t   rows[$];

    chaotic_ode_rhs_lorenz_chua_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // run limit
    initial
    begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    // saturating fixed-point helpers
    function automatic longint fx_clamp(longint v);
        if (v > WMAX_Q)
        begin
            clip_seen = 1'b1;
            return WMAX_Q;
        end
        if (v < WMIN_Q)
        begin
            clip_seen = 1'b1;
            return WMIN_Q;
        end
        return v;
    endfunction

    function automatic longint fx_add(longint a, longint b);
        return fx_clamp(a + b);
    endfunction

    function automatic longint fx_sub(longint a, longint b);
        return fx_clamp(a - b);
    endfunction

    // exact product, rounded half away from zero, then clipped
    function automatic longint fx_mul(longint a, longint b);
        logic signed [127:0] p;
        logic [127:0]        m;
        logic [127:0]        q;
        logic [127:0]        lim;
        bit                  neg;
        p   = a * b;
        neg = (a < 0) != (b < 0);
        m   = (p < 0) ? -p : p;
        q   = (m + (128'd1 << 23)) >> 24;
        lim = neg ? (128'd1 << (WORD_BITS - 1)) : (128'd1 << (WORD_BITS - 1)) - 1;
        if (q > lim)
        begin
            clip_seen = 1'b1;
            q = lim;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // derivative and tangent derivative of one point
    function automatic out_t derive_rates(in_t d);
        longint x, y, z, dx, dy, dz;
        longint rz, off, g, dg, gi, go, ax, a, a2, a3, s, dads, diff;
        longint r[6];
        out_t   o;
        x  = longint'(d.pos_x);
        y  = longint'(d.pos_y);
        z  = longint'(d.pos_z);
        dx = longint'(d.tangent_x);
        dy = longint'(d.tangent_y);
        dz = longint'(d.tangent_z);
        clip_seen = 1'b0;
        if (!mode_chua)
        begin
            rz   = fx_sub(rho_q, z);
            r[0] = fx_mul(sigma_q, fx_sub(y, x));
            r[1] = fx_sub(fx_mul(x, rz), y);
            r[2] = fx_sub(fx_mul(x, y), fx_mul(beta_q, z));
            r[3] = fx_mul(sigma_q, fx_sub(dy, dx));
            r[4] = fx_sub(fx_sub(fx_mul(dx, rz), dy), fx_mul(x, dz));
            r[5] = fx_sub(fx_add(fx_mul(dx, y), fx_mul(x, dy)), fx_mul(beta_q, dz));
        end
        else
        begin
            // diode: linear away from the corners, smoothstep blend near them
            off = fx_sub(m0_q, m1_q);
            ax  = (x < 0) ? -x : x;
            if (x > ONE_Q + EPS_Q)
            begin
                g  = fx_add(fx_mul(m1_q, x), off);
                dg = m1_q;
            end
            else if (x < -(ONE_Q + EPS_Q))
            begin
                g  = fx_sub(fx_mul(m1_q, x), off);
                dg = m1_q;
            end
            else if (ax < ONE_Q - EPS_Q)
            begin
                g  = fx_mul(m0_q, x);
                dg = m0_q;
            end
            else
            begin
                gi = fx_mul(m0_q, x);
                go = (x > 0) ? fx_add(fx_mul(m1_q, x), off) : fx_sub(fx_mul(m1_q, x), off);
                a  = (ax - (ONE_Q - EPS_Q)) * 25;
                if (a > ONE_Q)
                    a = ONE_Q;
                a2   = fx_mul(a, a);
                a3   = fx_mul(a2, a);
                s    = 3 * a2 - 2 * a3;
                dads = (6 * a - 6 * a2) * 25;
                if (x < 0)
                    dads = -dads;
                diff = fx_sub(go, gi);
                g    = fx_add(gi, fx_mul(diff, s));
                dg   = fx_add(fx_add(m0_q, fx_mul(fx_sub(m1_q, m0_q), s)),
                              fx_mul(diff, dads));
            end
            r[0] = fx_mul(alpha_q, fx_sub(fx_sub(y, x), g));
            r[1] = fx_add(fx_sub(x, y), z);
            r[2] = fx_sub(0, fx_mul(beta_q, y));
            r[3] = fx_mul(alpha_q, fx_sub(dy, fx_mul(dx, fx_add(ONE_Q, dg))));
            r[4] = fx_add(fx_sub(dx, dy), dz);
            r[5] = fx_sub(0, fx_mul(beta_q, dy));
        end
        o.rate_x         = word_t'(r[0]);
        o.rate_y         = word_t'(r[1]);
        o.rate_z         = word_t'(r[2]);
        o.tangent_rate_x = word_t'(r[3]);
        o.tangent_rate_y = word_t'(r[4]);
        o.tangent_rate_z = word_t'(r[5]);
        o.saturated      = clip_seen;
        return o;
    endfunction

    // random field value, biased to corners, extremes and moderate magnitudes
    function automatic word_t pick_word();
        longint v;
        case ($urandom_range(6))
            0, 1: v = longint'(word_t'({$urandom, $urandom}));
            2:    v = longint'($urandom_range(40 * 65536)) * 256 - 20 * ONE_Q * 256 / 256 * 256 / 256;
            3:    v = (($urandom_range(1)) ? 1 : -1) *
                      (ONE_Q + longint'($urandom_range(4 * EPS_Q)) - 2 * EPS_Q);
            4:    v = ($urandom_range(1)) ? WMAX_Q : WMIN_Q;
            5:    v = longint'($urandom_range(6)) - 3;
            default: v = longint'($urandom_range(2 * ONE_Q)) - ONE_Q;
        endcase
        return word_t'(v);
    endfunction

    function automatic in_t pick_item();
        in_t d;
        d.pos_x     = pick_word();
        d.pos_y     = pick_word();
        d.pos_z     = pick_word();
        d.tangent_x = pick_word();
        d.tangent_y = pick_word();
        d.tangent_z = pick_word();
        return d;
    endfunction

    function automatic in_t make_item(longint x, longint y, longint z,
                                      longint dx, longint dy, longint dz);
        in_t d;
        d.pos_x     = word_t'(x);
        d.pos_y     = word_t'(y);
        d.pos_z     = word_t'(z);
        d.tangent_x = word_t'(dx);
        d.tangent_y = word_t'(dy);
        d.tangent_z = word_t'(dz);
        return d;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", field, got, want, $realtime);
        mismatches++;
    endtask

    // wait for the pipeline to empty before touching the registers
    task automatic drain();
        while (expected_rates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, longint value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[WORD_BITS-1:0];
        @(posedge clk);
        case (idx)
            REG_SELECT:      mode_chua = value[0];
            REG_SIGMA:       sigma_q   = longint'(word_t'(value));
            REG_RHO:         rho_q     = longint'(word_t'(value));
            REG_BETA:        beta_q    = longint'(word_t'(value));
            REG_ALPHA:       alpha_q   = longint'(word_t'(value));
            REG_SLOPE_INNER: m0_q      = longint'(word_t'(value));
            REG_SLOPE_OUTER: m1_q      = longint'(word_t'(value));
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // offer one item and hold it until the transfer happens
    task automatic send_item(in_t d, bit typed, out_t want);
        @(negedge clk);
        while (gaps_on && $urandom_range(99) < 34)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do
            @(posedge clk);
        while (in_stall);
        expected_rates.push_back(typed ? want : derive_rates(d));
    endtask

    // output stall, with an occasional long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_request > 0)
        begin
            out_stall <= 1'b1;
            hold_request <= hold_request - 1;
        end
        else
            out_stall <= gaps_on && ($urandom_range(99) < 34);
    end

    // result check on each output transfer
    always @(posedge clk)
    begin
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_rates.size() == 0)
            begin
                $display("unexpected result at %0t", $realtime);
                mismatches++;
            end
            else
            begin
                want = expected_rates.pop_front();
                if (out_data.rate_x !== want.rate_x)
                    report_mismatch("rate_x", out_data.rate_x, want.rate_x);
                if (out_data.rate_y !== want.rate_y)
                    report_mismatch("rate_y", out_data.rate_y, want.rate_y);
                if (out_data.rate_z !== want.rate_z)
                    report_mismatch("rate_z", out_data.rate_z, want.rate_z);
                if (out_data.tangent_rate_x !== want.tangent_rate_x)
                    report_mismatch("tangent_rate_x", out_data.tangent_rate_x,
                                    want.tangent_rate_x);
                if (out_data.tangent_rate_y !== want.tangent_rate_y)
                    report_mismatch("tangent_rate_y", out_data.tangent_rate_y,
                                    want.tangent_rate_y);
                if (out_data.tangent_rate_z !== want.tangent_rate_z)
                    report_mismatch("tangent_rate_z", out_data.tangent_rate_z,
                                    want.tangent_rate_z);
                if (out_data.saturated !== want.saturated)
                    report_mismatch("saturated", out_data.saturated, want.saturated);
            end
        end
    end

    // stimulus
    initial
    begin
        out_t  zero_out;
        out_t  none;
        row_t  rw;
        in_t   d;
        longint c;
        int    n;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_write    = 1'b0;
        cfg_index    = REG_SELECT;
        cfg_data     = '0;
        out_stall    = 1'b0;
        hold_request = 0;
        gaps_on      = 1'b1;
        mismatches   = 0;
        zero_out     = '0;
        none         = '0;
        // reset values of the coefficient registers
        mode_chua = 1'b0;
        sigma_q   = 10 * ONE_Q;
        rho_q     = 28 * ONE_Q;
        beta_q    = (8 * ONE_Q + 1) / 3;
        alpha_q   = 9 * ONE_Q;
        m0_q      = -((1143 * ONE_Q + 500) / 1000);
        m1_q      = -((714 * ONE_Q + 500) / 1000);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: lorenz then chua, corners and extremes
        c = ONE_Q + EPS_Q;
        rows.push_back('{0, make_item(0, 0, 0, 0, 0, 0), 1, zero_out});
        rows.push_back('{0, make_item(ONE_Q, 2 * ONE_Q, 3 * ONE_Q, ONE_Q, -ONE_Q, ONE_Q / 2),
                         0, none});
        rows.push_back('{0, make_item(WMAX_Q, WMAX_Q, WMAX_Q, WMAX_Q, WMAX_Q, WMAX_Q), 0, none});
        rows.push_back('{0, make_item(WMIN_Q, WMIN_Q, WMIN_Q, WMIN_Q, WMIN_Q, WMIN_Q), 0, none});
        rows.push_back('{0, make_item(WMAX_Q, WMIN_Q, WMAX_Q, WMIN_Q, WMAX_Q, WMIN_Q), 0, none});
        rows.push_back('{0, make_item(-1, 1, -1, 1, -1, 1), 0, none});
        rows.push_back('{1, make_item(0, 0, 0, 0, 0, 0), 1, zero_out});
        rows.push_back('{1, make_item(c, ONE_Q, 0, ONE_Q, 0, 0), 0, none});
        rows.push_back('{1, make_item(-c, ONE_Q, 0, ONE_Q, 0, 0), 0, none});
        rows.push_back('{1, make_item(c + 1, 0, ONE_Q, ONE_Q, ONE_Q, 0), 0, none});
        rows.push_back('{1, make_item(-c - 1, 0, ONE_Q, ONE_Q, ONE_Q, 0), 0, none});
        rows.push_back('{1, make_item(ONE_Q - EPS_Q, 0, 0, ONE_Q, 0, ONE_Q), 0, none});
        rows.push_back('{1, make_item(-(ONE_Q - EPS_Q), 0, 0, ONE_Q, 0, ONE_Q), 0, none});
        rows.push_back('{1, make_item(ONE_Q - EPS_Q - 1, 0, 0, ONE_Q, 0, 0), 0, none});
        rows.push_back('{1, make_item(ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q), 0, none});
        rows.push_back('{1, make_item(-ONE_Q, 0, 0, -ONE_Q, 0, 0), 0, none});
        rows.push_back('{1, make_item(ONE_Q + EPS_Q / 2, 0, 0, ONE_Q, 0, 0), 0, none});
        rows.push_back('{1, make_item(WMAX_Q, WMAX_Q, WMAX_Q, WMAX_Q, WMAX_Q, WMAX_Q), 0, none});
        rows.push_back('{1, make_item(WMIN_Q, WMIN_Q, WMIN_Q, WMIN_Q, WMIN_Q, WMIN_Q), 0, none});
        rows.push_back('{1, make_item(WMIN_Q, WMAX_Q, WMIN_Q, WMAX_Q, WMIN_Q, WMAX_Q), 0, none});
        foreach (rows[i])
        begin
            rw = rows[i];
            if (rw.chua != mode_chua)
            begin
                // stop offering before the mode changes
                @(negedge clk);
                in_valid <= 1'b0;
                drain();
                write_reg(REG_SELECT, rw.chua);
            end
            send_item(rw.d, rw.typed, rw.want);
        end

        // random phases, each with a fresh register setting
        for (int ph = 0; ph < 10; ph++)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            drain();
            write_reg(REG_NONE, {$urandom, $urandom});
            if (ph == 0)
            begin
                write_reg(REG_SIGMA, WMAX_Q);
                write_reg(REG_RHO, WMIN_Q);
                write_reg(REG_BETA, WMAX_Q);
                write_reg(REG_ALPHA, WMIN_Q);
                write_reg(REG_SLOPE_INNER, WMAX_Q);
                write_reg(REG_SLOPE_OUTER, WMIN_Q);
            end
            else if (ph == 1)
            begin
                write_reg(REG_SIGMA, WMIN_Q);
                write_reg(REG_RHO, WMAX_Q);
                write_reg(REG_BETA, WMIN_Q);
                write_reg(REG_ALPHA, WMAX_Q);
                write_reg(REG_SLOPE_INNER, WMIN_Q);
                write_reg(REG_SLOPE_OUTER, WMAX_Q);
            end
            else if (ph < 4)
            begin
                // classic attractor coefficients
                write_reg(REG_SIGMA, 10 * ONE_Q);
                write_reg(REG_RHO, 28 * ONE_Q);
                write_reg(REG_BETA, (8 * ONE_Q + 1) / 3);
                write_reg(REG_ALPHA, 9 * ONE_Q + $urandom_range(ONE_Q));
                write_reg(REG_SLOPE_INNER, -((1143 * ONE_Q + 500) / 1000));
                write_reg(REG_SLOPE_OUTER, -((714 * ONE_Q + 500) / 1000));
            end
            else
            begin
                write_reg(REG_SIGMA, pick_word());
                write_reg(REG_RHO, pick_word());
                write_reg(REG_BETA, pick_word());
                write_reg(REG_ALPHA, pick_word());
                write_reg(REG_SLOPE_INNER, longint'($urandom_range(4 * ONE_Q)) - 2 * ONE_Q);
                write_reg(REG_SLOPE_OUTER, pick_word());
            end
            write_reg(REG_SELECT, ph[0] ^ ph[2]);
            gaps_on = (ph != 5);
            n = 160;
            for (int k = 0; k < n; k++)
            begin
                // long receiver hold-off while items keep arriving
                if (ph == 6 && k == 10)
                    hold_request = 120;
                send_item(pick_item(), 1'b0, none);
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;
        gaps_on = 1'b1;

        while (expected_rates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
